[rtl/ltib_pkg.sv]
// Package for the layer texture index batcher.
// Holds sizes, codes, the sequencer state type and the structs passed between modules.
// No dependencies.
package ltib_pkg;

  localparam int unsigned TILES        = 64;
  localparam int unsigned TILE_W       = 6;
  localparam int unsigned SCAN_W       = TILE_W + 1;
  localparam int unsigned LAYERS       = 4;
  localparam int unsigned LAYER_W      = 2;
  localparam int unsigned CODE_W       = 8;
  localparam int unsigned WORD_W       = LAYERS * CODE_W;
  localparam int unsigned TEX_CNT_W    = 5;
  localparam int unsigned MAX_TEXTURES = 16;
  localparam int unsigned INDEX_W      = 8;
  localparam int unsigned BEFORE_W     = 9;
  localparam int unsigned MATCH_W      = 7;
  localparam int unsigned START_W      = 11;
  localparam int unsigned COUNT_W      = 9;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_EMIT,
    ST_EMPTY
  } state_e;

  // What one lane found for the tile under inspection.
  typedef struct packed {
    logic prior;
    logic hit;
  } lane_res_t;

  typedef struct packed {
    logic clear;
    logic accum;
  } merge_ctrl_t;

endpackage

[rtl/ltib_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ltib_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/ltib_lane.sv]
// One lane of the tile scan: classifies the code of one layer of the current tile.
// Depends on ltib_pkg.
module ltib_lane (
  input  logic [ltib_pkg::LAYER_W-1:0]   lane_idx_i,
  input  logic [ltib_pkg::CODE_W-1:0]    code_i,
  input  logic [ltib_pkg::LAYER_W-1:0]   query_layer_i,
  input  logic [ltib_pkg::CODE_W-1:0]    query_texture_i,
  input  logic [ltib_pkg::TEX_CNT_W-1:0] tex_count_i,
  output ltib_pkg::lane_res_t            res_o
);
  import ltib_pkg::*;

  logic nonzero;
  logic lower_layer;
  logic same_layer;

  assign nonzero     = (code_i != '0);
  assign lower_layer = (lane_idx_i < query_layer_i);
  assign same_layer  = (lane_idx_i == query_layer_i);

  // A code counts towards earlier groups if it sits on a lower layer and is a
  // texture in use, or on the queried layer with a smaller texture.
  assign res_o.prior = nonzero &&
                       ((lower_layer && (code_i <= CODE_W'(tex_count_i))) ||
                        (same_layer && (code_i < query_texture_i)));
  assign res_o.hit   = nonzero && same_layer && (code_i == query_texture_i);

endmodule

[rtl/ltib_merge.sv]
// Merging stage: sums the lane findings into the prefix count and the match count.
// Depends on ltib_pkg.
module ltib_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ltib_pkg::merge_ctrl_t         ctrl_i,
  input  logic                          data_valid_i,
  input  ltib_pkg::lane_res_t           lane_i [ltib_pkg::LAYERS],
  output logic                          hit_o,
  output logic [ltib_pkg::BEFORE_W-1:0] before_o,
  output logic [ltib_pkg::MATCH_W-1:0]  matches_o
);
  import ltib_pkg::*;

  logic [BEFORE_W-1:0] before_q, before_d;
  logic [MATCH_W-1:0]  matches_q, matches_d;
  logic [BEFORE_W-1:0] tile_before;

  always_comb begin
    tile_before = '0;
    hit_o       = 1'b0;
    for (int i = 0; i < LAYERS; i++) begin
      tile_before = tile_before + BEFORE_W'(lane_i[i].prior);
      hit_o       = hit_o | lane_i[i].hit;
    end
  end

  always_comb begin
    before_d  = before_q;
    matches_d = matches_q;
    if (ctrl_i.clear) begin
      before_d  = '0;
      matches_d = '0;
    end else if (ctrl_i.accum && data_valid_i) begin
      before_d  = before_q + tile_before;
      matches_d = matches_q + MATCH_W'(hit_o);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q  <= '0;
      matches_q <= '0;
    end else begin
      before_q  <= before_d;
      matches_q <= matches_d;
    end
  end

  assign before_o  = before_q;
  assign matches_o = matches_q;

endmodule

[rtl/layer_texture_index_batcher_unit.sv]
// Top level of the layer texture index batcher.
// Depends on ltib_pkg, ltib_ram, ltib_lane and ltib_merge.
//
// Usage:
//   Items enter on start while busy is low. A load (func 0) writes the four
//   layer codes of one tile into the tile store and gives no result; busy
//   stays low. A query (func 1) raises busy and, if its texture is in range,
//   scans the store. The first pass reads one tile per cycle, four lanes
//   classify its layer codes, and the merging stage accumulates the prefix
//   and match counts. The second pass reads the tiles again and presents one
//   result for every matching tile, in tile order, with res_valid_o high for
//   exactly one cycle. A query with no matching tile, or with a texture out of
//   range, gives a single empty result. The last result of a query has last_o
//   set. The time a query with a valid texture takes is bound by the single
//   read port of the tile store; an invalid texture gives its empty result
//   through the ST_EMPTY state and the registered result outputs. A run of
//   matching results ends no later than the last busy cycle; an empty result
//   is presented in the first cycle after busy falls.
//   The receiver cannot stall; results are not held back.
//   Configuration: cfg_data_i writes texture_count whenever cfg_valid_i is
//   high; cfg_ready_o is always high. Reset clears the register and marks
//   every tile as empty through per-tile valid bits, so no clearing pass runs.
module layer_texture_index_batcher_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             func_i,
  input  logic [ltib_pkg::TILE_W-1:0]      tile_number_i,
  input  logic [ltib_pkg::CODE_W-1:0]      code_layer0_i,
  input  logic [ltib_pkg::CODE_W-1:0]      code_layer1_i,
  input  logic [ltib_pkg::CODE_W-1:0]      code_layer2_i,
  input  logic [ltib_pkg::CODE_W-1:0]      code_layer3_i,
  input  logic [ltib_pkg::LAYER_W-1:0]     query_layer_i,
  input  logic [ltib_pkg::CODE_W-1:0]      query_texture_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ltib_pkg::TEX_CNT_W-1:0]   cfg_data_i,
  output logic                             res_valid_o,
  output logic [ltib_pkg::INDEX_W-1:0]     index_a_o,
  output logic [ltib_pkg::INDEX_W-1:0]     index_b_o,
  output logic [ltib_pkg::INDEX_W-1:0]     index_c_o,
  output logic [ltib_pkg::INDEX_W-1:0]     index_d_o,
  output logic [ltib_pkg::INDEX_W-1:0]     index_e_o,
  output logic [ltib_pkg::INDEX_W-1:0]     index_f_o,
  output logic [ltib_pkg::START_W-1:0]     face_start_o,
  output logic [ltib_pkg::COUNT_W-1:0]     face_count_o,
  output logic                             empty_res_o,
  output logic                             last_o
);
  import ltib_pkg::*;

  state_e state_q, state_d;

  logic [TEX_CNT_W-1:0] tex_count_q;
  logic [TEX_CNT_W-1:0] eff_count;
  logic [LAYER_W-1:0]   layer_q;
  logic [CODE_W-1:0]    texture_q;
  logic [TILES-1:0]     tile_valid_q;
  logic [SCAN_W-1:0]    scan_q, scan_d;
  logic                 data_v_q;
  logic [TILE_W-1:0]    tile_q;
  logic                 rd_valid_q;
  logic [MATCH_W-1:0]   emit_cnt_q, emit_cnt_d;

  logic                 accept;
  logic                 load_acc;
  logic                 query_acc;
  logic                 tex_ok;
  logic                 rd_en;
  logic                 pass_done;
  logic                 emit_hit;
  logic                 emit_empty;
  merge_ctrl_t          mctrl;

  logic [WORD_W-1:0]    wdata;
  logic [WORD_W-1:0]    rdata;
  logic [WORD_W-1:0]    word;
  lane_res_t            lane_res [LAYERS];
  logic                 hit;
  logic [BEFORE_W-1:0]  prior_cnt;
  logic [MATCH_W-1:0]   match_cnt;
  logic [INDEX_W-1:0]   base;
  logic [START_W-1:0]   start_val;
  logic [COUNT_W-1:0]   count_val;

  assign accept    = start && !busy;
  assign load_acc  = accept && (func_i == FUNC_LOAD);
  assign query_acc = accept && (func_i == FUNC_QUERY);
  assign busy      = (state_q != ST_IDLE);

  assign eff_count = (tex_count_q > TEX_CNT_W'(MAX_TEXTURES)) ?
                     TEX_CNT_W'(MAX_TEXTURES) : tex_count_q;
  assign tex_ok    = (query_texture_i != '0) &&
                     (query_texture_i <= CODE_W'(eff_count));

  assign pass_done = (scan_q == SCAN_W'(TILES)) && !data_v_q;

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tex_count_q <= cfg_data_i;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          state_d = tex_ok ? ST_COUNT : ST_EMPTY;
        end
      end
      ST_COUNT: begin
        if (pass_done) begin
          state_d = (match_cnt == '0) ? ST_EMPTY : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pass_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    rd_en       = 1'b0;
    mctrl.clear = 1'b0;
    mctrl.accum = 1'b0;
    emit_hit    = 1'b0;
    emit_empty  = 1'b0;
    unique case (state_q)
      ST_IDLE:  mctrl.clear = 1'b1;
      ST_COUNT: begin
        rd_en       = (scan_q < SCAN_W'(TILES));
        mctrl.accum = 1'b1;
      end
      ST_EMIT: begin
        rd_en    = (scan_q < SCAN_W'(TILES));
        emit_hit = data_v_q && hit;
      end
      ST_EMPTY: emit_empty = 1'b1;
      default:  mctrl.clear = 1'b1;
    endcase
  end

  always_comb begin
    scan_d = scan_q;
    if (state_d != state_q) begin
      scan_d = '0;
    end else if (rd_en) begin
      scan_d = scan_q + SCAN_W'(1);
    end
  end

  assign emit_cnt_d = (state_q == ST_IDLE) ? '0 :
                      (emit_hit ? emit_cnt_q + MATCH_W'(1) : emit_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scan_q       <= '0;
      data_v_q     <= 1'b0;
      emit_cnt_q   <= '0;
      tile_valid_q <= '0;
      rd_valid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      data_v_q   <= rd_en;
      emit_cnt_q <= emit_cnt_d;
      if (load_acc) begin
        tile_valid_q[tile_number_i] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= tile_valid_q[scan_q[TILE_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      layer_q   <= query_layer_i;
      texture_q <= query_texture_i;
    end
    if (rd_en) begin
      tile_q <= scan_q[TILE_W-1:0];
    end
  end

  // Tile store: layer 0 in the low byte. Every tile number names a tile.
  assign wdata = {code_layer3_i, code_layer2_i, code_layer1_i, code_layer0_i};

  ltib_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TILES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (tile_number_i),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (scan_q[TILE_W-1:0]),
    .rdata_o (rdata)
  );

  // A tile never loaded since reset reads as all layers empty.
  assign word = rd_valid_q ? rdata : '0;

  for (genvar g = 0; g < LAYERS; g++) begin : g_lane
    ltib_lane u_lane (
      .lane_idx_i      (LAYER_W'(g)),
      .code_i          (word[g*CODE_W +: CODE_W]),
      .query_layer_i   (layer_q),
      .query_texture_i (texture_q),
      .tex_count_i     (eff_count),
      .res_o           (lane_res[g])
    );
  end

  ltib_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (mctrl),
    .data_valid_i (data_v_q),
    .lane_i       (lane_res),
    .hit_o        (hit),
    .before_o     (prior_cnt),
    .matches_o    (match_cnt)
  );

  // Six indices per matching tile.
  assign base      = {tile_q, 2'b00};
  assign start_val = (START_W'(prior_cnt) << 2) + (START_W'(prior_cnt) << 1);
  assign count_val = (COUNT_W'(match_cnt) << 2) + (COUNT_W'(match_cnt) << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= emit_hit || emit_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_hit) begin
      index_a_o    <= base;
      index_b_o    <= base + INDEX_W'(1);
      index_c_o    <= base + INDEX_W'(2);
      index_d_o    <= base + INDEX_W'(1);
      index_e_o    <= base + INDEX_W'(3);
      index_f_o    <= base + INDEX_W'(2);
      face_start_o <= start_val;
      face_count_o <= count_val;
      empty_res_o  <= 1'b0;
      last_o       <= ((emit_cnt_q + MATCH_W'(1)) == match_cnt);
    end else if (emit_empty) begin
      index_a_o    <= '0;
      index_b_o    <= '0;
      index_c_o    <= '0;
      index_d_o    <= '0;
      index_e_o    <= '0;
      index_f_o    <= '0;
      face_start_o <= '0;
      face_count_o <= '0;
      empty_res_o  <= 1'b1;
      last_o       <= 1'b1;
    end
  end

endmodule

[rtl/ltib_checker.sv]
// Port-level checker for the layer texture index batcher, bound to the top level.
// Depends on layer_texture_index_batcher_unit and ltib_pkg.
module ltib_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           busy,
  input logic                           res_valid_o,
  input logic [ltib_pkg::START_W-1:0]   face_start_o,
  input logic [ltib_pkg::COUNT_W-1:0]   face_count_o,
  input logic                           empty_res_o,
  input logic                           last_o
);

  // Results only follow a cycle in which a query was under way.
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result without a query in progress");

  // An empty result closes its query and carries no group.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && empty_res_o) |->
      (last_o && (face_start_o == '0) && (face_count_o == '0)))
    else $error("empty result malformed");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !empty_res_o) |-> (face_count_o != '0))
    else $error("matching result with zero face count");

  // Within a run of results the group fields do not change.
  a_group_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |=> (!res_valid_o || ($stable(face_start_o) &&
      $stable(face_count_o))))
    else $error("group fields changed inside a transaction run");

endmodule

bind layer_texture_index_batcher_unit ltib_checker u_ltib_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy         (busy),
  .res_valid_o  (res_valid_o),
  .face_start_o (face_start_o),
  .face_count_o (face_count_o),
  .empty_res_o  (empty_res_o),
  .last_o       (last_o)
);
